### rtl/bfdh_pkg.sv
package bfdh_pkg;
    localparam int STORE_BITS = 65536;
    localparam int MAX_PROBES = 8;
    localparam int IDX_W      = $clog2(STORE_BITS);
    localparam int FB_W       = 17;
    localparam int NH_W       = 4;
    localparam int HASH_W     = 64;
    localparam int PRB_W      = $clog2(MAX_PROBES + 1);
    localparam int MOD_W      = IDX_W + 1;

    localparam logic [0:0] CFG_FILTER_BITS = 1'b0;
    localparam logic [0:0] CFG_NUM_HASHES  = 1'b1;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // one probe handed from the front to the store side;
    // skip marks a query with no probes, answered 1 without a store read
    typedef struct packed {
        logic             is_query;
        logic             last;
        logic             skip;
        logic [IDX_W-1:0] idx;
    } probe_t;
endpackage

### rtl/bfdh_front.sv
// Probe generator: walks hash_a + n*hash_b and reduces each value with a
// restoring divider, one quotient bit per cycle.
module bfdh_front
    import bfdh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              req_type,
    input  logic [HASH_W-1:0] hash_a,
    input  logic [HASH_W-1:0] hash_b,
    input  logic [MOD_W-1:0]  modulus,
    input  logic [PRB_W-1:0]  probes,
    output logic              pq_valid,
    output probe_t            pq_data,
    input  logic              pq_full
);
    typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} state_t;

    state_t            state_reg, state_next;
    logic [HASH_W-1:0] mix_reg, mix_next, stride_reg, stride_next;
    logic [HASH_W-1:0] dividend_reg, dividend_next;
    logic [MOD_W-1:0]  rem_reg, rem_next, mod_reg, mod_next;
    logic [6:0]        bit_reg, bit_next;
    logic [PRB_W-1:0]  left_reg, left_next;
    logic              query_reg, query_next;
    logic              skip_reg, skip_next;
    logic [MOD_W:0]    trial;
    logic [MOD_W:0]    shifted;

    assign in_stall    = (state_reg != S_IDLE);
    assign shifted     = {rem_reg, dividend_reg[HASH_W-1]};
    assign trial       = shifted - {1'b0, mod_reg};

    assign pq_valid          = (state_reg == S_PUSH);
    assign pq_data.is_query  = query_reg;
    assign pq_data.last      = (left_reg == PRB_W'(1));
    assign pq_data.skip      = skip_reg;
    assign pq_data.idx       = rem_reg[IDX_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        mix_next      = mix_reg;
        stride_next   = stride_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        mod_next      = mod_reg;
        bit_next      = bit_reg;
        left_next     = left_reg;
        query_next    = query_reg;
        skip_next     = skip_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (probes == '0)
                    begin
                        // no probes: insert is dropped, query rides the
                        // queue as a marker so answers stay in order
                        if (req_type == REQ_QUERY)
                        begin
                            rem_next   = '0;
                            mod_next   = modulus;
                            left_next  = PRB_W'(1);
                            query_next = 1'b1;
                            skip_next  = 1'b1;
                            state_next = S_PUSH;
                        end
                    end
                    else
                    begin
                        mix_next      = hash_a + hash_b;
                        stride_next   = hash_b;
                        dividend_next = hash_a;
                        rem_next      = '0;
                        mod_next      = modulus;
                        bit_next      = 7'd0;
                        left_next     = probes;
                        query_next    = req_type;
                        skip_next     = 1'b0;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                dividend_next = {dividend_reg[HASH_W-2:0], 1'b0};
                if (trial[MOD_W])
                    rem_next = shifted[MOD_W-1:0];
                else
                    rem_next = trial[MOD_W-1:0];
                bit_next = bit_reg + 7'd1;
                if (bit_reg == 7'(HASH_W - 1))
                    state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (!pq_full)
                begin
                    left_next = left_reg - PRB_W'(1);
                    if (left_reg == PRB_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        dividend_next = mix_reg;
                        mix_next      = mix_reg + stride_reg;
                        rem_next      = '0;
                        bit_next      = 7'd0;
                        state_next    = S_DIV;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mix_reg      <= mix_next;
        stride_reg   <= stride_next;
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        mod_reg      <= mod_next;
        bit_reg      <= bit_next;
        query_reg    <= query_next;
        skip_reg     <= skip_next;
    end

    a_rem_lt_mod: assert property (@(posedge clk) disable iff (!rst_n)
        pq_valid |-> ({1'b0, pq_data.idx} < mod_reg))
        else $error("probe index not reduced");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH && !pq_full && pq_data.last) |=> !in_stall)
        else $error("front did not return to idle");
    a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pq_valid && pq_full) |=> (pq_valid && $stable(pq_data)))
        else $error("probe changed while blocked");
endmodule

### rtl/bfdh_fifo.sv
// Short probe queue between the front and the store side.
module bfdh_fifo
    import bfdh_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  probe_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output probe_t head
);
    probe_t     mem_reg [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;

    assign full      = (cnt_reg == 3'd4);
    assign not_empty = (cnt_reg != 3'd0);
    assign head      = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wr_reg <= wr_reg + 2'd1;
            if (pop && not_empty)
                rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'((push && !full) ? 1 : 0)
                       - 3'((pop && not_empty) ? 1 : 0);
        end
    end

    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4) else $error("queue count overflow");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!push && !pop) |=> $stable(cnt_reg)) else $error("queue count drift");
endmodule

### rtl/bfdh_back.sv
// Store side: clears the store after reset, then sets the bit of each insert
// probe, reads each query probe before the next pop and builds the answer.
module bfdh_back
    import bfdh_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pq_not_empty,
    input  probe_t pq_head,
    output logic   pq_pop,
    output logic   busy_clear,
    output logic   out_valid,
    input  logic   out_stall,
    output logic   possibly_present
);
    typedef enum logic [1:0] {S_CLR, S_RUN, S_READ, S_OUT} state_t;

    logic             mem [STORE_BITS];
    state_t           state_reg;
    logic [IDX_W-1:0] clr_reg;
    logic             rd_reg, hit_reg, last_reg, res_reg;

    assign busy_clear       = (state_reg == S_CLR);
    assign out_valid        = (state_reg == S_OUT);
    assign possibly_present = res_reg;
    assign pq_pop           = (state_reg == S_RUN) && pq_not_empty;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLR)
            mem[clr_reg] <= 1'b0;
        else if (pq_pop && !pq_head.is_query)
            mem[pq_head.idx] <= 1'b1;
        rd_reg <= mem[pq_head.idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            clr_reg        <= '0;
            hit_reg        <= 1'b1;
            last_reg       <= 1'b0;
            res_reg        <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + IDX_W'(1);
                    if (clr_reg == IDX_W'(STORE_BITS - 1))
                        state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    if (pq_pop)
                    begin
                        last_reg <= pq_head.last;
                        if (pq_head.skip)
                        begin
                            // query without probes
                            res_reg   <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else if (pq_head.is_query)
                            state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    if (last_reg)
                    begin
                        res_reg   <= hit_reg & rd_reg;
                        hit_reg   <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        hit_reg   <= hit_reg & rd_reg;
                        state_reg <= S_RUN;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_RUN;
                end
                default: state_reg <= S_RUN;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(possibly_present)))
        else $error("result changed while stalled");
    a_no_pop_clr: assert property (@(posedge clk) disable iff (!rst_n)
        busy_clear |-> !pq_pop) else $error("probe taken during clear");
    a_read_next: assert property (@(posedge clk) disable iff (!rst_n)
        (pq_pop && pq_head.is_query && !pq_head.skip) |=> (state_reg == S_READ))
        else $error("query probe not read");
endmodule

### rtl/bloom_filter_double_hash.sv
// Channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | req_type, hash_a, hash_b
// out     | out_valid | out_stall | possibly_present
// cfg     | cfg_valid | cfg_ready | cfg_index, cfg_data; cfg_ready is a ready, not a stall
//
// Each probe is reduced in the bit-serial modulo unit and then pushed, so a
// request holds the input off while its probes are worked after its beat is
// taken (insert with no probes: not at all; query with no probes: for its
// push). After reset the store is swept clear, one bit a cycle, and no
// item is taken during the sweep. Queries may stall on out_stall; the probe
// queue lets the front keep working meanwhile.
module bloom_filter_double_hash
    import bfdh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              req_type,
    input  logic [HASH_W-1:0] hash_a,
    input  logic [HASH_W-1:0] hash_b,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              possibly_present,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [FB_W-1:0]   cfg_data
);
    logic [FB_W-1:0] fb_reg;
    logic [NH_W-1:0] nh_reg;
    logic [MOD_W-1:0] modulus;
    logic [PRB_W-1:0] probes;
    logic front_stall, busy_clear;
    logic pq_valid, pq_full, pq_pop, pq_not_empty;
    probe_t pq_data, pq_head;

    assign cfg_ready = 1'b1;

    // clamp the registers to the ranges the store supports
    assign modulus = (fb_reg == '0) ? MOD_W'(1) :
                     (fb_reg > FB_W'(STORE_BITS)) ? MOD_W'(STORE_BITS) :
                     MOD_W'(fb_reg);
    assign probes  = (nh_reg > NH_W'(MAX_PROBES)) ? PRB_W'(MAX_PROBES) :
                     PRB_W'(nh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_reg <= FB_W'(65536);
            nh_reg <= NH_W'(4);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_FILTER_BITS)
                fb_reg <= cfg_data;
            else
                nh_reg <= cfg_data[NH_W-1:0];
        end
    end

    // hold input off during the clearing sweep
    assign in_stall = front_stall | busy_clear;

    bfdh_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid & ~busy_clear), .in_stall(front_stall),
        .req_type(req_type), .hash_a(hash_a), .hash_b(hash_b),
        .modulus(modulus), .probes(probes),
        .pq_valid(pq_valid), .pq_data(pq_data), .pq_full(pq_full)
    );

    bfdh_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(pq_valid), .push_data(pq_data), .full(pq_full),
        .pop(pq_pop), .not_empty(pq_not_empty), .head(pq_head)
    );

    bfdh_back u_back (
        .clk(clk), .rst_n(rst_n),
        .pq_not_empty(pq_not_empty), .pq_head(pq_head), .pq_pop(pq_pop),
        .busy_clear(busy_clear),
        .out_valid(out_valid), .out_stall(out_stall),
        .possibly_present(possibly_present)
    );

    a_no_take_clr: assert property (@(posedge clk) disable iff (!rst_n)
        busy_clear |-> in_stall) else $error("input taken during clear");
    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        (modulus != '0) && (modulus <= MOD_W'(STORE_BITS)))
        else $error("modulus out of range");
    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        probes <= PRB_W'(MAX_PROBES)) else $error("probe count out of range");
endmodule

### tb/bloom_membership_checker.sv
module bloom_membership_checker
    import bfdh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              req_type,
    input  logic [HASH_W-1:0] hash_a,
    input  logic [HASH_W-1:0] hash_b,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              possibly_present,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [FB_W-1:0]   cfg_data,
    output int                pending,
    output int                fail_count
);
    logic              shadow_store [STORE_BITS];
    logic [FB_W-1:0]   shadow_fb;
    logic [NH_W-1:0]   shadow_nh;
    logic              answer_q [$];

    task automatic report(input string what, input logic got, input logic want);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        fail_count++;
    endtask

    function automatic logic [IDX_W-1:0] cell_of(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b,
                                                 input int n);
        logic [HASH_W-1:0] mix;
        logic [HASH_W-1:0] m;
        m = (shadow_fb == 0) ? 64'd1 :
            (shadow_fb > STORE_BITS) ? 64'(STORE_BITS) : 64'(shadow_fb);
        mix = a + 64'(n) * b;
        return IDX_W'(mix % m);
    endfunction

    // insert sets cells; query pushes its expected answer
    task automatic take_request(input logic rt, input logic [HASH_W-1:0] a,
                                input logic [HASH_W-1:0] b);
        int k;
        logic hit;
        k = (shadow_nh > MAX_PROBES) ? MAX_PROBES : int'(shadow_nh);
        hit = 1'b1;
        for (int n = 0; n < k; n++)
        begin
            if (rt == REQ_INSERT)
                shadow_store[cell_of(a, b, n)] = 1'b1;
            else if (!shadow_store[cell_of(a, b, n)])
                hit = 1'b0;
        end
        if (rt == REQ_QUERY)
            answer_q.push_back(hit);
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
        shadow_fb = 17'd65536;
        shadow_nh = 4'd4;
        for (int i = 0; i < STORE_BITS; i++)
            shadow_store[i] = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (answer_q.size() == 0)
                    report("unexpected result beat", possibly_present, 1'b0);
                else if (possibly_present !== answer_q[0])
                    report("possibly_present", possibly_present, answer_q[0]);
                if (answer_q.size() != 0)
                    void'(answer_q.pop_front());
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_FILTER_BITS)
                    shadow_fb = cfg_data;
                else
                    shadow_nh = cfg_data[NH_W-1:0];
            end
            if (in_valid && !in_stall)
                take_request(req_type, hash_a, hash_b);
            pending = answer_q.size();
        end
    end
endmodule

### tb/tb_bloom_filter_double_hash.sv
module tb_bloom_filter_double_hash;
    import bfdh_pkg::*;

    // cycles without any accepted beat before we give up; covers the
    // clearing sweep after reset plus margin
    localparam int WATCHDOG_LIMIT = 300000;
    // settle time for inserts still in flight (up to 8 probes, padded)
    localparam int SETTLE_CYCLES  = 2000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              req_type;
    logic [HASH_W-1:0] hash_a;
    logic [HASH_W-1:0] hash_b;
    logic              out_valid;
    logic              out_stall;
    logic              possibly_present;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [FB_W-1:0]   cfg_data;

    int pending;
    int fail_count;
    int idle_cycles;
    bit quiet;            // when set, neither side inserts gaps

    logic [2*HASH_W-1:0] key_log [$];   // keys inserted so far, for replay queries

    bloom_filter_double_hash dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .hash_a(hash_a), .hash_b(hash_b),
        .out_valid(out_valid), .out_stall(out_stall),
        .possibly_present(possibly_present),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bloom_membership_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .hash_a(hash_a), .hash_b(hash_b),
        .out_valid(out_valid), .out_stall(out_stall),
        .possibly_present(possibly_present),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .fail_count(fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog: any accepted beat on any channel resets the count
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_bloom_filter_double_hash: done, errors");
            $finish;
        end
    end

    // result side: per beat draw a stall length, then open up until taken
    initial
    begin
        int w;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            w = quiet ? 0 : $urandom_range(0, 16);
            if (w != 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic logic [HASH_W-1:0] rand_hash();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, 63'($urandom)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one request beat; called at a falling edge, returns at a falling edge
    // with valid still high so back-to-back beats need no toggle
    task automatic send_request(input logic rt, input logic [HASH_W-1:0] a,
                                input logic [HASH_W-1:0] b);
        int g;
        g = quiet ? 0 : $urandom_range(0, 16);
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        hash_a   <= a;
        hash_b   <= b;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        if (rt == REQ_INSERT)
            key_log.push_back({a, b});
    endtask

    // stop sending, let every query answer, then let trailing inserts finish
    task automatic drain_all();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [FB_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    int fb_set [8] = '{65536, 1, 0, 131071, 37, 200, 1000, 65536};
    int nh_set [8] = '{4, 1, 8, 15, 0, 3, 2, 8};

    initial
    begin
        logic [2*HASH_W-1:0] k;
        logic [HASH_W-1:0]   a;
        logic [HASH_W-1:0]   b;
        int                  pick;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = REQ_INSERT;
        hash_a    = '0;
        hash_b    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FILTER_BITS;
        cfg_data  = '0;
        quiet     = 1'b0;
        idle_cycles = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset config: empty store, wraparound of the stride sum
        send_request(REQ_QUERY,  '0, '0);
        send_request(REQ_INSERT, '0, '0);
        send_request(REQ_QUERY,  '0, '0);
        send_request(REQ_INSERT, '1, '1);
        send_request(REQ_QUERY,  '1, '1);
        send_request(REQ_QUERY,  '1, 64'd1);
        send_request(REQ_INSERT, 64'h8000_0000_0000_0000, '1);
        send_request(REQ_QUERY,  64'h8000_0000_0000_0000, '1);

        for (int ph = 0; ph < 8; ph++)
        begin
            drain_all();
            write_reg(CFG_FILTER_BITS, FB_W'(fb_set[ph]));
            // upper data bits are don't-care for the probe count
            write_reg(CFG_NUM_HASHES,
                      (FB_W'($urandom) & ~FB_W'(15)) | FB_W'(nh_set[ph]));
            quiet = (ph % 3 == 2);

            // a couple of fixed beats per setting: zero probes, modulus
            // zero and clamped sizes all show up here
            send_request(REQ_QUERY,  '1, 64'd12345);
            send_request(REQ_INSERT, '1, 64'd12345);
            send_request(REQ_QUERY,  '1, 64'd12345);

            for (int i = 0; i < 110; i++)
            begin
                if (i == 55)
                begin
                    // mid-phase pause until every answer is back
                    in_valid <= 1'b0;
                    while (pending != 0)
                        @(negedge clk);
                    quiet = ~quiet;
                end
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    send_request(REQ_INSERT, rand_hash(), rand_hash());
                else if (pick < 8 && key_log.size() != 0)
                begin
                    // replay an inserted key, so hits are common
                    k = key_log[$urandom_range(0, key_log.size() - 1)];
                    a = k[2*HASH_W-1:HASH_W];
                    b = k[HASH_W-1:0];
                    if (pick == 7)
                        b = b ^ (64'd1 << $urandom_range(0, 63));
                    send_request(REQ_QUERY, a, b);
                end
                else
                    send_request(REQ_QUERY, rand_hash(), rand_hash());
            end
        end

        drain_all();
        if (fail_count == 0)
            $display("tb_bloom_filter_double_hash: done, clean");
        else
            $display("tb_bloom_filter_double_hash: done, errors");
        $finish;
    end
endmodule

### bloom_filter_double_hash.f
rtl/bfdh_pkg.sv
rtl/bfdh_front.sv
rtl/bfdh_fifo.sv
rtl/bfdh_back.sv
rtl/bloom_filter_double_hash.sv
tb/bloom_membership_checker.sv
tb/tb_bloom_filter_double_hash.sv
